/* hw/rtl/usb_device_wedge_watchdog_top_assert.svh */
// Assertion macros for the wedge watchdog checker.
// Each macro checks on the rising edge of clk_i and is quiet while rst_ni is low.
`ifndef USB_DEVICE_WEDGE_WATCHDOG_TOP_ASSERT_SVH
`define USB_DEVICE_WEDGE_WATCHDOG_TOP_ASSERT_SVH

// Same-cycle implication.
`define UWDW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UWDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/uwdw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package uwdw_pkg;

  // Fixed field widths of the channels, the burst counter and configuration
  localparam int unsigned NowBits   = 32;
  localparam int unsigned MsgBits   = 10;
  localparam int unsigned BurstBits = 32;
  localparam int unsigned CfgBits   = 16;
  localparam int unsigned CfgIdxBits = 3;

  // Watchdog timing constants (milliseconds) and limits
  localparam int unsigned BurstGapMs         = 1000;
  localparam int unsigned DriverlessSettleMs = 3000;
  localparam int unsigned DriverlessMax      = 3;
  localparam int unsigned RetryFastMs        = 6000;
  localparam int unsigned RetrySlowMs        = 30000;
  localparam int unsigned RetryFastCount     = 5;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_NUDGE_SILENCE  = 3'd0,
    CFG_NUDGE_BURST    = 3'd1,
    CFG_PROBE_SILENCE  = 3'd2,
    CFG_PROBE_FAST     = 3'd3,
    CFG_PROBE_SLOW     = 3'd4,
    CFG_PROBE_FAST_CNT = 3'd5,
    CFG_PROBE_FAIL_LIM = 3'd6,
    CFG_DISCARD_WINDOW = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] nudge_silence_ms;
    logic [15:0] nudge_burst_msgs;
    logic [15:0] probe_silence_ms;
    logic [15:0] probe_fast_ms;
    logic [15:0] probe_slow_ms;
    logic [15:0] probe_fast_count;
    logic [7:0]  probe_fail_limit;
    logic [15:0] discard_window_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    nudge_silence_ms:  16'd1200,
    nudge_burst_msgs:  16'd24,
    probe_silence_ms:  16'd1500,
    probe_fast_ms:     16'd500,
    probe_slow_ms:     16'd5000,
    probe_fast_count:  16'd6,
    probe_fail_limit:  8'd2,
    discard_window_ms: 16'd400
  };

  // One tick word as held in the input stage
  typedef struct packed {
    logic [NowBits-1:0] now_ms;
    logic [MsgBits-1:0] msg_count;
    logic               bus_running;
    logic               driver_bound;
    logic               probe_ok;
  } tick_t;

  // One result word
  typedef struct packed {
    logic discard_packets;
    logic clear_halt_request;
    logic probe_request;
    logic replug_request;
    logic recovery_done;
    logic recovery_active;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/uwdw_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface uwdw_in_if
  import uwdw_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [NowBits-1:0] now_ms;
  logic [MsgBits-1:0] msg_count;
  logic               bus_running;
  logic               driver_bound;
  logic               probe_ok;

  modport source (
    output valid, now_ms, msg_count, bus_running, driver_bound, probe_ok,
    input  ready
  );

  modport sink (
    input  valid, now_ms, msg_count, bus_running, driver_bound, probe_ok,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/uwdw_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface uwdw_out_if;
  logic valid;
  logic ready;
  logic discard_packets;
  logic clear_halt_request;
  logic probe_request;
  logic replug_request;
  logic recovery_done;
  logic recovery_active;

  modport source (
    output valid, discard_packets, clear_halt_request, probe_request,
           replug_request, recovery_done, recovery_active,
    input  ready
  );

  modport sink (
    input  valid, discard_packets, clear_halt_request, probe_request,
           replug_request, recovery_done, recovery_active,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/usb_device_wedge_watchdog_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// USB device wedge watchdog.
// Input channel in_i: one word per millisecond service tick (timestamp, message
// count, bus-running and driver-bound flags, probe result). Output channel out_o:
// one result word per tick (discard, clear-halt, probe, replug, done, active).
// A word is taken when valid and ready are both high.
// Ticks pass the input register, then the result register. Throughput: one
// tick per clock unless stalled; the input register, the single pass through
// the watchdog logic and the result register sustain a word every cycle.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more tick; ready drops only when both are full.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
// clock edge; write only while no tick is in flight.
// Reset (rst_ni low, asynchronous): registers return to their defaults, all
// watchdog state clears, both stages empty; ticks are taken right after reset.

module usb_device_wedge_watchdog_top
  import uwdw_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [CfgBits-1:0]    cfg_data_i,
  uwdw_in_if.sink                    in_i,
  uwdw_out_if.source                 out_o
);

  cfg_t  cfg_q;
  tick_t tick_q;
  logic  tick_v_q;
  res_t  res;
  res_t  res_q;
  logic  res_v_q;
  logic  step;

  // Advance the tick when the result register is free or drains now
  assign step       = tick_v_q && (!res_v_q || out_o.ready);
  assign in_i.ready = !tick_v_q || step;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NUDGE_SILENCE:  cfg_q.nudge_silence_ms  <= cfg_data_i;
        CFG_NUDGE_BURST:    cfg_q.nudge_burst_msgs  <= cfg_data_i;
        CFG_PROBE_SILENCE:  cfg_q.probe_silence_ms  <= cfg_data_i;
        CFG_PROBE_FAST:     cfg_q.probe_fast_ms     <= cfg_data_i;
        CFG_PROBE_SLOW:     cfg_q.probe_slow_ms     <= cfg_data_i;
        CFG_PROBE_FAST_CNT: cfg_q.probe_fast_count  <= cfg_data_i;
        CFG_PROBE_FAIL_LIM: cfg_q.probe_fail_limit  <= cfg_data_i[7:0];
        CFG_DISCARD_WINDOW: cfg_q.discard_window_ms <= cfg_data_i;
        default:            cfg_q                   <= cfg_q;
      endcase
    end
  end

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_v_q <= 1'b0;
    end else if (in_i.ready) begin
      tick_v_q <= in_i.valid;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      tick_q.now_ms       <= in_i.now_ms;
      tick_q.msg_count    <= in_i.msg_count;
      tick_q.bus_running  <= in_i.bus_running;
      tick_q.driver_bound <= in_i.driver_bound;
      tick_q.probe_ok     <= in_i.probe_ok;
    end
  end

  uwdw_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .tick_i (tick_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (step) begin
      res_v_q <= 1'b1;
    end else if (out_o.ready) begin
      res_v_q <= 1'b0;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid              = res_v_q;
  assign out_o.discard_packets    = res_q.discard_packets;
  assign out_o.clear_halt_request = res_q.clear_halt_request;
  assign out_o.probe_request      = res_q.probe_request;
  assign out_o.replug_request     = res_q.replug_request;
  assign out_o.recovery_done      = res_q.recovery_done;
  assign out_o.recovery_active    = res_q.recovery_active;

endmodule

`default_nettype wire

/* hw/rtl/uwdw_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module uwdw_core
  import uwdw_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire tick_t tick_i,
  input  wire cfg_t  cfg_i,
  output res_t       res_o
);

  localparam logic [TIME_BITS-1:0] BurstGap   = TIME_BITS'(BurstGapMs);
  localparam logic [TIME_BITS-1:0] DrvSettle  = TIME_BITS'(DriverlessSettleMs);
  localparam logic [TIME_BITS-1:0] RetryFast  = TIME_BITS'(RetryFastMs);
  localparam logic [TIME_BITS-1:0] RetrySlow  = TIME_BITS'(RetrySlowMs);

  logic                 rec_q, rec_d;
  logic [7:0]           retries_q, retries_d;
  logic [TIME_BITS-1:0] rec_start_q, rec_start_d;
  logic                 disc_v_q, disc_v_d;
  logic [TIME_BITS-1:0] disc_end_q, disc_end_d;
  logic [TIME_BITS-1:0] last_act_q, last_act_d;
  logic [BurstBits-1:0] burst_q, burst_d;
  logic                 nudge_q, nudge_d;
  logic [7:0]           fails_q, fails_d;
  logic [15:0]          succ_q, succ_d;
  logic [TIME_BITS-1:0] last_probe_q, last_probe_d;
  logic                 was_run_q, was_run_d;
  logic [TIME_BITS-1:0] no_drv_q, no_drv_d;
  logic [1:0]           dl_att_q, dl_att_d;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] disc_left;
  logic [TIME_BITS-1:0] silence;
  logic [TIME_BITS-1:0] interval;
  logic [TIME_BITS-1:0] retry_after;
  logic [BurstBits:0]   burst_sum;
  logic                 discard, halt, probe, replug, done;

  assign now_t = TIME_BITS'(tick_i.now_ms);

  // Work out next state and the result word for the current tick
  always_comb begin
    rec_d        = rec_q;
    retries_d    = retries_q;
    rec_start_d  = rec_start_q;
    disc_v_d     = disc_v_q;
    disc_end_d   = disc_end_q;
    last_act_d   = last_act_q;
    burst_d      = burst_q;
    nudge_d      = nudge_q;
    fails_d      = fails_q;
    succ_d       = succ_q;
    last_probe_d = last_probe_q;
    was_run_d    = was_run_q;
    no_drv_d     = no_drv_q;
    dl_att_d     = dl_att_q;
    discard      = 1'b0;
    halt         = 1'b0;
    probe        = 1'b0;
    replug       = 1'b0;
    done         = 1'b0;
    disc_left    = disc_end_q - now_t;
    burst_sum    = '0;
    silence      = '0;
    interval     = '0;
    retry_after  = (retries_q >= 8'(RetryFastCount)) ? RetrySlow : RetryFast;

    // Discard window: open while the signed distance to its end is positive
    if (disc_v_q) begin
      discard = (disc_left != '0) && !disc_left[TIME_BITS-1];
      if (!discard) begin
        disc_v_d = 1'b0;
      end
    end

    // Message activity restarts silence and counts the burst
    if (tick_i.msg_count != '0) begin
      if ((now_t - last_act_q) > BurstGap) begin
        burst_d = '0;
      end
      burst_sum  = {1'b0, burst_d} + (BurstBits + 1)'(tick_i.msg_count);
      burst_d    = burst_sum[BurstBits] ? '1 : burst_sum[BurstBits-1:0];
      last_act_d = now_t;
      nudge_d    = 1'b0;
      fails_d    = '0;
      succ_d     = '0;
    end

    if (rec_q) begin
      // Wait for re-enumeration, retry with backoff
      if (tick_i.bus_running && tick_i.driver_bound) begin
        rec_d        = 1'b0;
        retries_d    = '0;
        disc_v_d     = 1'b1;
        disc_end_d   = now_t + TIME_BITS'(cfg_i.discard_window_ms);
        last_act_d   = now_t;
        burst_d      = '0;
        nudge_d      = 1'b0;
        fails_d      = '0;
        succ_d       = '0;
        last_probe_d = now_t;
        was_run_d    = 1'b1;
        done         = 1'b1;
      end else if ((now_t - rec_start_q) >= retry_after) begin
        if (tick_i.bus_running) begin
          rec_d     = 1'b0;
          was_run_d = 1'b0;
        end else begin
          if (retries_q != 8'hFF) begin
            retries_d = retries_q + 8'd1;
          end
          rec_start_d = now_t;
          replug      = 1'b1;
        end
      end
    end else begin
      // Rearm the watch when the bus comes up
      if (tick_i.bus_running && !was_run_q) begin
        last_act_d   = now_t;
        burst_d      = '0;
        nudge_d      = 1'b0;
        fails_d      = '0;
        succ_d       = '0;
        last_probe_d = now_t;
        no_drv_d     = now_t;
      end
      was_run_d = tick_i.bus_running;
      if (!tick_i.bus_running) begin
        dl_att_d = '0;
      end else if (!tick_i.driver_bound) begin
        // Replug a driverless device, a bounded number of times
        if (((now_t - no_drv_d) >= DrvSettle) && (dl_att_d < 2'(DriverlessMax))) begin
          dl_att_d    = dl_att_d + 2'd1;
          rec_d       = 1'b1;
          retries_d   = '0;
          rec_start_d = now_t;
          replug      = 1'b1;
        end
      end else begin
        silence  = now_t - last_act_d;
        no_drv_d = now_t;
        // One-shot clear-halt after a large burst stops
        if (!nudge_d && (silence >= TIME_BITS'(cfg_i.nudge_silence_ms))) begin
          nudge_d = 1'b1;
          if (burst_d >= BurstBits'(cfg_i.nudge_burst_msgs)) begin
            halt = 1'b1;
          end
        end
        // Liveness probing, fast interval first then slow
        if (silence >= TIME_BITS'(cfg_i.probe_silence_ms)) begin
          interval = (succ_d >= cfg_i.probe_fast_count) ? TIME_BITS'(cfg_i.probe_slow_ms)
                                                        : TIME_BITS'(cfg_i.probe_fast_ms);
          if ((now_t - last_probe_d) >= interval) begin
            last_probe_d = now_t;
            probe        = 1'b1;
            if (tick_i.probe_ok) begin
              if (succ_d != 16'hFFFF) begin
                succ_d = succ_d + 16'd1;
              end
              fails_d = '0;
            end else begin
              if (fails_d != 8'hFF) begin
                fails_d = fails_d + 8'd1;
              end
              if (fails_d >= cfg_i.probe_fail_limit) begin
                rec_d       = 1'b1;
                retries_d   = '0;
                rec_start_d = now_t;
                replug      = 1'b1;
              end
            end
          end
        end
      end
    end

    res_o.discard_packets    = discard;
    res_o.clear_halt_request = halt;
    res_o.probe_request      = probe;
    res_o.replug_request     = replug;
    res_o.recovery_done      = done;
    res_o.recovery_active    = rec_d;
  end

  // Commit state when a tick is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q        <= 1'b0;
      retries_q    <= '0;
      rec_start_q  <= '0;
      disc_v_q     <= 1'b0;
      disc_end_q   <= '0;
      last_act_q   <= '0;
      burst_q      <= '0;
      nudge_q      <= 1'b0;
      fails_q      <= '0;
      succ_q       <= '0;
      last_probe_q <= '0;
      was_run_q    <= 1'b0;
      no_drv_q     <= '0;
      dl_att_q     <= '0;
    end else if (step_i) begin
      rec_q        <= rec_d;
      retries_q    <= retries_d;
      rec_start_q  <= rec_start_d;
      disc_v_q     <= disc_v_d;
      disc_end_q   <= disc_end_d;
      last_act_q   <= last_act_d;
      burst_q      <= burst_d;
      nudge_q      <= nudge_d;
      fails_q      <= fails_d;
      succ_q       <= succ_d;
      last_probe_q <= last_probe_d;
      was_run_q    <= was_run_d;
      no_drv_q     <= no_drv_d;
      dl_att_q     <= dl_att_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/uwdw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "usb_device_wedge_watchdog_top_assert.svh"

module uwdw_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic discard_packets_i,
  input wire logic clear_halt_request_i,
  input wire logic probe_request_i,
  input wire logic replug_request_i,
  input wire logic recovery_done_i,
  input wire logic recovery_active_i
);

  logic [5:0] out_word;
  logic       out_fire;

  assign out_word = {discard_packets_i, clear_halt_request_i, probe_request_i,
                     replug_request_i, recovery_done_i, recovery_active_i};
  assign out_fire = out_valid_i && out_ready_i;

  // Hold a stalled result word
  `UWDW_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word), "result word changed while stalled")

  // A replug leaves a recovery in flight
  `UWDW_ASSERT_NOW(a_replug_active, out_fire && replug_request_i, recovery_active_i, "replug without active recovery")

  // A finished recovery is no longer in flight
  `UWDW_ASSERT_NOW(a_done_idle, out_fire && recovery_done_i, !recovery_active_i, "recovery done while still active")

  // Replug and recovery completion exclude each other
  `UWDW_ASSERT_NOW(a_replug_done, out_fire, !(replug_request_i && recovery_done_i), "replug and recovery done together")

endmodule

bind usb_device_wedge_watchdog_top uwdw_checker u_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .discard_packets_i    (out_o.discard_packets),
  .clear_halt_request_i (out_o.clear_halt_request),
  .probe_request_i      (out_o.probe_request),
  .replug_request_i     (out_o.replug_request),
  .recovery_done_i      (out_o.recovery_done),
  .recovery_active_i    (out_o.recovery_active)
);

`default_nettype wire
